/* sv/ufd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_pkg
// shared constants and types of the uart frame deframer
// ----------------------------------------------------------------------------
package ufd_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 256;

	localparam logic [7:0] HDR_A     = 8'hAA;
	localparam logic [7:0] HDR_B     = 8'h55;
	localparam logic [7:0] TAIL_BYTE = 8'hFE;

	// header (2) + command + length (2) before payload, checksum + tail after
	localparam int unsigned PAYLOAD_START  = 5;
	localparam int unsigned FRAME_OVERHEAD = 7;
	localparam int unsigned POS_COMMAND    = 2;
	localparam int unsigned POS_LEN_HI     = 3;
	localparam int unsigned POS_LEN_LO     = 4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_NO_HEADER = 3'd2;
	localparam logic [2:0] ST_LEN_TAIL  = 3'd3;
	localparam logic [2:0] ST_CHECKSUM  = 3'd4;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic       is_payload;
		logic [7:0] payload_index;
		logic       frame_done;
		logic [2:0] frame_status;
		logic [7:0] frame_command;
		logic [7:0] payload_length;
	} result_t;

endpackage
`default_nettype wire

/* sv/ufd_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_tracker
// frame tracking state and per-byte result logic
// ----------------------------------------------------------------------------
module ufd_tracker #(
	parameter int unsigned BUFFER_BYTES = ufd_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             buffer_end,
	output ufd_pkg::result_t      result
);

	localparam int unsigned CW   = $clog2(BUFFER_BYTES + 1);
	// wide enough for length + 7 and for any position
	localparam int unsigned CMPW = ((CW > 17) ? CW : 17) + 1;
	localparam logic [CW-1:0]   BUF_LIMIT = CW'(BUFFER_BYTES);
	localparam logic [CMPW-1:0] PSTART    = CMPW'(ufd_pkg::PAYLOAD_START);
	localparam logic [CMPW-1:0] OVERHEAD  = CMPW'(ufd_pkg::FRAME_OVERHEAD);

	logic          header_found_q;
	logic [7:0]    previous_byte_q;
	logic [CW-1:0] bytes_seen_q;
	logic [CW-1:0] frame_position_q;
	logic [7:0]    running_sum_q;
	logic [7:0]    command_hold_q;
	logic [15:0]   length_field_q;
	logic [7:0]    received_checksum_q;

	logic          n_header_found;
	logic [7:0]    n_previous_byte;
	logic [CW-1:0] n_bytes_seen;
	logic [CW-1:0] n_frame_position;
	logic [7:0]    n_running_sum;
	logic [7:0]    n_command_hold;
	logic [15:0]   n_length_field;
	logic [7:0]    n_received_checksum;

	logic            active;
	logic            hdr_pair;
	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] len_w;
	logic [CMPW-1:0] pay_end;
	logic [CMPW-1:0] npos_w;
	logic [CMPW-1:0] nlen_w;
	logic [CMPW-1:0] pay_off;
	logic            past_start;
	logic            in_payload;
	logic [2:0]      status;

	always_comb begin
		active   = bytes_seen_q < BUF_LIMIT;
		hdr_pair = (bytes_seen_q != '0) &&
			(((previous_byte_q == ufd_pkg::HDR_A) && (rx_byte == ufd_pkg::HDR_B)) ||
			 ((previous_byte_q == ufd_pkg::HDR_B) && (rx_byte == ufd_pkg::HDR_A)));
		pos_w      = CMPW'(frame_position_q);
		len_w      = CMPW'(length_field_q);
		pay_end    = len_w + PSTART;
		pay_off    = pos_w - PSTART;
		past_start = pos_w >= PSTART;
		in_payload = active && header_found_q && past_start && (pos_w < pay_end);

		n_header_found      = header_found_q;
		n_previous_byte     = previous_byte_q;
		n_bytes_seen        = bytes_seen_q;
		n_frame_position    = frame_position_q;
		n_running_sum       = running_sum_q;
		n_command_hold      = command_hold_q;
		n_length_field      = length_field_q;
		n_received_checksum = received_checksum_q;

		if (active) begin
			if (header_found_q) begin
				if (pos_w == CMPW'(ufd_pkg::POS_COMMAND)) begin
					n_command_hold = rx_byte;
				end else if (pos_w == CMPW'(ufd_pkg::POS_LEN_HI)) begin
					n_length_field = {rx_byte, length_field_q[7:0]};
				end else if (pos_w == CMPW'(ufd_pkg::POS_LEN_LO)) begin
					n_length_field = {length_field_q[15:8], rx_byte};
				end
				// sum covers everything before the checksum byte
				if (!past_start || (pos_w < pay_end)) begin
					n_running_sum = running_sum_q + rx_byte;
				end
				if (past_start && (pos_w == pay_end)) begin
					n_received_checksum = rx_byte;
				end
				n_frame_position = frame_position_q + 1'b1;
			end else if (hdr_pair) begin
				n_header_found   = 1'b1;
				n_frame_position = CW'(ufd_pkg::POS_COMMAND);
				n_running_sum    = previous_byte_q + rx_byte;
			end
			n_previous_byte = rx_byte;
			n_bytes_seen    = bytes_seen_q + 1'b1;
		end

		// verdict on the state after this byte
		npos_w = CMPW'(n_frame_position);
		nlen_w = CMPW'(n_length_field);
		priority if (n_bytes_seen < CW'(ufd_pkg::FRAME_OVERHEAD)) begin
			status = ufd_pkg::ST_TOO_SHORT;
		end else if (!n_header_found) begin
			status = ufd_pkg::ST_NO_HEADER;
		end else if ((npos_w < PSTART) || (npos_w != nlen_w + OVERHEAD) ||
				(n_previous_byte != ufd_pkg::TAIL_BYTE)) begin
			status = ufd_pkg::ST_LEN_TAIL;
		end else if (n_running_sum != n_received_checksum) begin
			status = ufd_pkg::ST_CHECKSUM;
		end else begin
			status = ufd_pkg::ST_OK;
		end

		result.echo_byte      = rx_byte;
		result.is_payload     = in_payload;
		result.payload_index  = in_payload ? pay_off[7:0] : 8'd0;
		result.frame_done     = buffer_end;
		result.frame_status   = buffer_end ? status : ufd_pkg::ST_OK;
		result.frame_command  = (buffer_end && (status == ufd_pkg::ST_OK)) ?
			n_command_hold : 8'd0;
		result.payload_length = (buffer_end && (status == ufd_pkg::ST_OK)) ?
			n_length_field[7:0] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_found_q      <= 1'b0;
			previous_byte_q     <= '0;
			bytes_seen_q        <= '0;
			frame_position_q    <= '0;
			running_sum_q       <= '0;
			command_hold_q      <= '0;
			length_field_q      <= '0;
			received_checksum_q <= '0;
		end else if (advance) begin
			if (buffer_end) begin
				header_found_q      <= 1'b0;
				previous_byte_q     <= '0;
				bytes_seen_q        <= '0;
				frame_position_q    <= '0;
				running_sum_q       <= '0;
				command_hold_q      <= '0;
				length_field_q      <= '0;
				received_checksum_q <= '0;
			end else begin
				header_found_q      <= n_header_found;
				previous_byte_q     <= n_previous_byte;
				bytes_seen_q        <= n_bytes_seen;
				frame_position_q    <= n_frame_position;
				running_sum_q       <= n_running_sum;
				command_hold_q      <= n_command_hold;
				length_field_q      <= n_length_field;
				received_checksum_q <= n_received_checksum;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/uart_frame_deframer.sv */
// path: an accepted item is held in the input register, then in the result register, which drives the output
// throughput: one item per cycle while out_stall is low, set by the single pass of the frame tracker
// between the input register and the result register
// reset: arst_n clears both pipeline valids and all frame tracking state;
// the tracking state also clears itself after every item with buffer_end set
`default_nettype none
// ----------------------------------------------------------------------------
// uart_frame_deframer
// header / length / checksum / tail checker over one receive buffer
// ----------------------------------------------------------------------------
module uart_frame_deframer #(
	parameter int unsigned BUFFER_BYTES = ufd_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input item channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       buffer_end,
	// result item channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      echo_byte,
	output logic            is_payload,
	output logic [7:0]      payload_index,
	output logic            frame_done,
	output logic [2:0]      frame_status,
	output logic [7:0]      frame_command,
	output logic [7:0]      payload_length
);

	// stage 1: registered input item
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// stage 2: registered result item
	logic             valid_s2;
	ufd_pkg::result_t result_s2;

	ufd_pkg::result_t result_c;

	logic load_s2;   // result register can take a new item
	logic load_s1;   // input register can take a new item
	logic advance;   // stage 1 item moves into the result register

	// each stage moves when it is empty or its successor moves
	assign load_s2  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign advance  = valid_s1 && load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= rx_byte;
			end_s1  <= buffer_end;
		end
	end

	// state update and verdict for the byte in stage 1
	ufd_tracker #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.rx_byte   (byte_s1),
		.buffer_end(end_s1),
		.result    (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	assign out_valid      = valid_s2;
	assign echo_byte      = result_s2.echo_byte;
	assign is_payload     = result_s2.is_payload;
	assign payload_index  = result_s2.payload_index;
	assign frame_done     = result_s2.frame_done;
	assign frame_status   = result_s2.frame_status;
	assign frame_command  = result_s2.frame_command;
	assign payload_length = result_s2.payload_length;

endmodule
`default_nettype wire

/* sim/ufd_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ufd_result_checker
// watches both channels of the uart frame deframer, predicts the result item
// of every accepted byte and compares it field by field with the dut output
// ----------------------------------------------------------------------------
module ufd_result_checker #(
	parameter int unsigned BUFFER_BYTES = ufd_pkg::BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       buffer_end,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] echo_byte,
	input  logic       is_payload,
	input  logic [7:0] payload_index,
	input  logic       frame_done,
	input  logic [2:0] frame_status,
	input  logic [7:0] frame_command,
	input  logic [7:0] payload_length,
	output int         mismatch_count,
	output int         pending_count
);
	import ufd_pkg::*;

	// frame tracking state of the predictor
	logic        in_frame;
	logic [7:0]  last_byte;
	int unsigned bytes_taken;
	int unsigned frame_pos;
	logic [7:0]  sum_acc;
	logic [7:0]  command_hold;
	logic [15:0] length_field;
	logic [7:0]  checksum_seen;

	result_t byte_results_due[$];

	task automatic clear_tracking();
		in_frame      = 1'b0;
		last_byte     = '0;
		bytes_taken   = 0;
		frame_pos     = 0;
		sum_acc       = '0;
		command_hold  = '0;
		length_field  = '0;
		checksum_seen = '0;
	endtask

	task automatic track_frame_byte(input logic [7:0] b, input logic last, output result_t r);
		int unsigned pos;
		int unsigned len;
		r = '0;
		r.echo_byte  = b;
		r.frame_done = last;
		// bytes past the buffer size are echoed but not tracked
		if (bytes_taken < BUFFER_BYTES) begin
			if (in_frame) begin
				pos = frame_pos;
				len = length_field;
				if (pos == POS_COMMAND)
					command_hold = b;
				else if (pos == POS_LEN_HI)
					length_field[15:8] = b;
				else if (pos == POS_LEN_LO)
					length_field[7:0] = b;
				if (pos < PAYLOAD_START || pos < len + PAYLOAD_START)
					sum_acc = sum_acc + b;
				if (pos >= PAYLOAD_START && pos == len + PAYLOAD_START)
					checksum_seen = b;
				if (pos >= PAYLOAD_START && (pos - PAYLOAD_START) < len) begin
					r.is_payload    = 1'b1;
					r.payload_index = 8'(pos - PAYLOAD_START);
				end
				frame_pos = pos + 1;
			end else if (bytes_taken > 0 &&
					((last_byte == HDR_A && b == HDR_B) ||
					 (last_byte == HDR_B && b == HDR_A))) begin
				in_frame  = 1'b1;
				frame_pos = POS_COMMAND;
				sum_acc   = last_byte + b;
			end
			last_byte   = b;
			bytes_taken = bytes_taken + 1;
		end
		if (last) begin
			len = length_field;
			if (bytes_taken < FRAME_OVERHEAD)
				r.frame_status = ST_TOO_SHORT;
			else if (!in_frame)
				r.frame_status = ST_NO_HEADER;
			else if (frame_pos < PAYLOAD_START || frame_pos != len + FRAME_OVERHEAD ||
					last_byte != TAIL_BYTE)
				r.frame_status = ST_LEN_TAIL;
			else if (sum_acc != checksum_seen)
				r.frame_status = ST_CHECKSUM;
			else begin
				r.frame_status   = ST_OK;
				r.frame_command  = command_hold;
				r.payload_length = length_field[7:0];
			end
			clear_tracking();
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count = mismatch_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			clear_tracking();
			byte_results_due.delete();
			mismatch_count = 0;
			pending_count  = 0;
		end else begin
			// results first: a byte accepted at this edge cannot be out yet
			if (out_valid && !out_stall) begin
				if (byte_results_due.size() == 0) begin
					$display("%0t ns: result with none expected, echo_byte %0d",
						$time, echo_byte);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = byte_results_due.pop_front();
					compare_field("echo_byte", want.echo_byte, echo_byte);
					compare_field("is_payload", want.is_payload, is_payload);
					compare_field("payload_index", want.payload_index, payload_index);
					compare_field("frame_done", want.frame_done, frame_done);
					compare_field("frame_status", want.frame_status, frame_status);
					compare_field("frame_command", want.frame_command, frame_command);
					compare_field("payload_length", want.payload_length, payload_length);
				end
			end
			if (in_valid && !in_stall) begin
				track_frame_byte(rx_byte, buffer_end, fresh);
				byte_results_due.push_back(fresh);
			end
			pending_count = byte_results_due.size();
		end
	end

endmodule

/* sim/uart_frame_deframer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_frame_deframer_tb
// streams receive buffers through the deframer: a few hand-made buffers, then
// random well-formed frames, damaged frames, noise and overlong buffers, with
// random gaps on the sender and random stalls on the receiver
// ----------------------------------------------------------------------------
module uart_frame_deframer_tb;
	import ufd_pkg::*;

	localparam int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF;
	localparam int          ITEM_TARGET  = 1700;
	// cycles with no item moving on either channel before giving up
	localparam int          QUIET_LIMIT  = 2000;
	// cycles to let pass after the last result
	localparam int          DRAIN_CYCLES = 8;

	// ways to damage a frame
	typedef enum int {
		FLAW_NONE,
		FLAW_CHECKSUM,
		FLAW_TAIL,
		FLAW_SHORT,
		FLAW_TRAILING,
		FLAW_HUGE_LEN
	} flaw_e;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte    = '0;
	logic       buffer_end = 1'b0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] echo_byte;
	logic       is_payload;
	logic [7:0] payload_index;
	logic       frame_done;
	logic [2:0] frame_status;
	logic [7:0] frame_command;
	logic [7:0] payload_length;

	int mismatch_count;
	int pending_count;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int items_sent         = 0;
	int quiet_cycles       = 0;

	// bytes of the receive buffer being built
	logic [7:0] rx_buffer[$];

	always #2 clk = ~clk;

	uart_frame_deframer #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.buffer_end    (buffer_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.echo_byte     (echo_byte),
		.is_payload    (is_payload),
		.payload_index (payload_index),
		.frame_done    (frame_done),
		.frame_status  (frame_status),
		.frame_command (frame_command),
		.payload_length(payload_length)
	);

	ufd_result_checker #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.buffer_end    (buffer_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.echo_byte     (echo_byte),
		.is_payload    (is_payload),
		.payload_index (payload_index),
		.frame_done    (frame_done),
		.frame_status  (frame_status),
		.frame_command (frame_command),
		.payload_length(payload_length),
		.mismatch_count(mismatch_count),
		.pending_count (pending_count)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// watchdog: counts cycles in which no item moves on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// offer one byte, with a random gap first, and hold it until taken
	task automatic send_item(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		rx_byte    <= b;
		buffer_end <= last;
		// stall is sampled at the edge, before the dut updates it
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// the whole buffer, buffer_end on its last byte
	task automatic send_buffer();
		foreach (rx_buffer[i])
			send_item(rx_buffer[i], i == rx_buffer.size() - 1);
	endtask

	// sender goes quiet until every result is out
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
	endtask

	// append header, command, length, payload, checksum and tail, then damage
	task automatic add_frame(input int n, input flaw_e flaw);
		logic [7:0]  sum;
		logic [7:0]  first;
		logic [7:0]  b;
		logic [15:0] decl_len;
		first    = $urandom_range(1) ? HDR_A : HDR_B;
		decl_len = 16'(n);
		// length far beyond what follows
		if (flaw == FLAW_HUGE_LEN)
			decl_len[15:8] = 8'($urandom_range(1, 255));
		rx_buffer.push_back(first);
		rx_buffer.push_back(first ^ 8'hFF);
		b = 8'($urandom);
		rx_buffer.push_back(b);
		rx_buffer.push_back(decl_len[15:8]);
		rx_buffer.push_back(decl_len[7:0]);
		sum = 8'hFF + b + decl_len[15:8] + decl_len[7:0];
		repeat (n) begin
			b = 8'($urandom);
			rx_buffer.push_back(b);
			sum = sum + b;
		end
		if (flaw == FLAW_CHECKSUM)
			sum = sum + 8'($urandom_range(1, 255));
		rx_buffer.push_back(sum);
		if (flaw == FLAW_TAIL)
			rx_buffer.push_back(TAIL_BYTE ^ 8'($urandom_range(1, 255)));
		else
			rx_buffer.push_back(TAIL_BYTE);
		// frame cut off before its end
		if (flaw == FLAW_SHORT)
			repeat ($urandom_range(1, 3)) void'(rx_buffer.pop_back());
		// junk after the tail
		if (flaw == FLAW_TRAILING)
			repeat ($urandom_range(1, 3)) rx_buffer.push_back(8'($urandom));
	endtask

	// mostly frames with random content, some damaged, some noise, rarely huge
	task automatic build_random_buffer();
		int pick;
		int fill_to;
		pick = $urandom_range(99);
		rx_buffer.delete();
		if (pick < 77) begin
			repeat ($urandom_range(0, 2)) rx_buffer.push_back(8'($urandom));
			if (pick < 55)
				add_frame($urandom_range(0, 24), FLAW_NONE);
			else
				add_frame($urandom_range(0, 24), flaw_e'($urandom_range(1, 5)));
		end else if (pick < 97) begin
			// noise, often with header and tail bytes mixed in
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(4))
					0: rx_buffer.push_back(HDR_A);
					1: rx_buffer.push_back(HDR_B);
					2: rx_buffer.push_back(TAIL_BYTE);
					default: rx_buffer.push_back(8'($urandom));
				endcase
			end
		end else if (pick < 98) begin
			add_frame($urandom_range(100, BUFFER_BYTES - FRAME_OVERHEAD),
				$urandom_range(1) ? FLAW_NONE : flaw_e'($urandom_range(1, 5)));
		end else begin
			// overlong buffer, the frame followed by junk past the size
			add_frame($urandom_range(0, 20), FLAW_NONE);
			fill_to = BUFFER_BYTES + $urandom_range(1, 8);
			while (rx_buffer.size() < fill_to)
				rx_buffer.push_back(8'($urandom));
		end
	endtask

	initial begin
		sender_idle_pct    = 33;
		receiver_stall_pct = 66;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// good frame with one payload byte
		rx_buffer.delete();
		add_frame(1, FLAW_NONE);
		send_buffer();
		// too short although a header is there
		rx_buffer = '{HDR_B, HDR_A, 8'h01};
		send_buffer();
		// header so late that the length field never completes
		rx_buffer = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, HDR_A, HDR_B};
		send_buffer();
		// no header anywhere, byte extremes
		rx_buffer = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, TAIL_BYTE, HDR_A};
		send_buffer();
		hold_until_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 33;
					receiver_stall_pct = 66;
				end
				1: begin
					sender_idle_pct    = 66;
					receiver_stall_pct = 33;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
					// largest payload filling the buffer, then bytes past its size
					rx_buffer.delete();
					add_frame(BUFFER_BYTES - FRAME_OVERHEAD, FLAW_NONE);
					repeat ($urandom_range(1, 8)) rx_buffer.push_back(8'($urandom));
					send_buffer();
				end
			endcase
			while (items_sent < (phase + 1) * ITEM_TARGET / 3) begin
				build_random_buffer();
				send_buffer();
				if ($urandom_range(99) < 3)
					hold_until_drained();
			end
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
